// ----- hdl/lfp_pkg.sv -----
// shared types, constants and the dither table of the led flicker generator
`timescale 1ns / 1ps
`default_nettype none
package lfp_pkg;

  // sizes
  localparam int unsigned LedCountDef = 4;
  localparam int unsigned LevelCount  = 32;
  localparam int unsigned LevelW      = 5;
  localparam int unsigned MaskW       = 4;
  localparam int unsigned SeedW       = 32;
  localparam int unsigned BrightW     = 5;
  localparam int unsigned DelayW      = 16;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 32;
  localparam int unsigned BitCntW     = 5;

  // linear congruential generator
  localparam logic [SeedW-1:0] LcgMul  = 32'd1664525;
  localparam logic [SeedW-1:0] LcgInc  = 32'd1013904223;

  // register reset values
  localparam logic [SeedW-1:0]   SeedRst       = 32'd12345678;
  localparam logic [BrightW-1:0] BrightSpanRst = 5'd20;
  localparam logic [BrightW-1:0] BrightBaseRst = 5'd11;
  localparam logic [DelayW-1:0]  DelaySpanRst  = 16'd750;
  localparam logic [DelayW-1:0]  DelayBaseRst  = 16'd250;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgSeedStart  = 3'd0,
    CfgBrightSpan = 3'd1,
    CfgBrightBase = 3'd2,
    CfgDelaySpan  = 3'd3,
    CfgDelayBase  = 3'd4
  } lfp_cfg_e;

  // controller states
  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StBrightDiv,
    StBrightApply,
    StDelayDiv,
    StDelayApply,
    StUpdate
  } lfp_state_e;

  // controller to datapath
  typedef struct packed {
    logic led_clr;
    logic led_next;
    logic lcg_step;
    logic div_start;
    logic div_step;
    logic sel_delay;
    logic load_pattern;
    logic load_hold;
    logic tick_update;
  } lfp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hold_zero;
    logic led_last;
    logic div_last;
  } lfp_sts_t;

  // dither word for one brightness level
  function automatic logic [31:0] dither_word(input logic [LevelW-1:0] level);
    logic [31:0] w;
    unique case (level)
      5'd0:  w = 32'h00000000;
      5'd1:  w = 32'h00010000;
      5'd2:  w = 32'h00010001;
      5'd3:  w = 32'h80200800;
      5'd4:  w = 32'h01010101;
      5'd5:  w = 32'h82080820;
      5'd6:  w = 32'h84108410;
      5'd7:  w = 32'h84112410;
      5'd8:  w = 32'h11111111;
      5'd9:  w = 32'h11249111;
      5'd10: w = 32'h12491249;
      5'd11: w = 32'h25225252;
      5'd12: w = 32'h25252525;
      5'd13: w = 32'h25525522;
      5'd14: w = 32'h25552555;
      5'd15: w = 32'h25555555;
      5'd16: w = 32'h55555555;
      5'd17: w = 32'h55575555;
      5'd18: w = 32'h57555755;
      5'd19: w = 32'h57575755;
      5'd20: w = 32'h57575757;
      5'd21: w = 32'h57577775;
      5'd22: w = 32'h57777577;
      5'd23: w = 32'h57777777;
      5'd24: w = 32'h77777777;
      5'd25: w = 32'hf7777777;
      5'd26: w = 32'hf777f777;
      5'd27: w = 32'hf7f7f777;
      5'd28: w = 32'hf7f7f7f7;
      5'd29: w = 32'hf7fff7f7;
      5'd30: w = 32'hf7fffff7;
      5'd31: w = 32'hf0000000;
      default: w = 32'h00000000;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/lfp_ctrl.sv -----
// controller state machine: led scan, reload sequencing and output word handshake
`timescale 1ns / 1ps
`default_nettype none
module lfp_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            tick_valid_i,
  output logic                 tick_ready_o,
  input  wire logic            tick_i,
  output logic                 led_mask_valid_o,
  input  wire logic            led_mask_ready_i,
  output lfp_pkg::lfp_cmd_t    cmd_o,
  input  wire lfp_pkg::lfp_sts_t sts_i
);

  lfp_pkg::lfp_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || led_mask_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lfp_pkg::StIdle: begin
        if (tick_valid_i && tick_i) state_d = lfp_pkg::StScan;
      end
      lfp_pkg::StScan: begin
        if (sts_i.hold_zero) state_d = lfp_pkg::StBrightDiv;
        else if (sts_i.led_last) state_d = lfp_pkg::StUpdate;
      end
      lfp_pkg::StBrightDiv: begin
        if (sts_i.div_last) state_d = lfp_pkg::StBrightApply;
      end
      lfp_pkg::StBrightApply: state_d = lfp_pkg::StDelayDiv;
      lfp_pkg::StDelayDiv: begin
        if (sts_i.div_last) state_d = lfp_pkg::StDelayApply;
      end
      lfp_pkg::StDelayApply: begin
        state_d = sts_i.led_last ? lfp_pkg::StUpdate : lfp_pkg::StScan;
      end
      lfp_pkg::StUpdate: begin
        if (out_free) state_d = lfp_pkg::StIdle;
      end
      default: state_d = lfp_pkg::StIdle;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      lfp_pkg::StIdle: begin
        cmd_o.led_clr = 1'b1;
      end
      lfp_pkg::StScan: begin
        if (sts_i.hold_zero) begin
          cmd_o.lcg_step  = 1'b1;
          cmd_o.div_start = 1'b1;
        end else if (!sts_i.led_last) begin
          cmd_o.led_next = 1'b1;
        end
      end
      lfp_pkg::StBrightDiv: begin
        cmd_o.div_step = 1'b1;
      end
      lfp_pkg::StBrightApply: begin
        cmd_o.load_pattern = 1'b1;
        cmd_o.lcg_step     = 1'b1;
        cmd_o.div_start    = 1'b1;
      end
      lfp_pkg::StDelayDiv: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.sel_delay = 1'b1;
      end
      lfp_pkg::StDelayApply: begin
        cmd_o.sel_delay = 1'b1;
        cmd_o.load_hold = 1'b1;
        cmd_o.led_next  = !sts_i.led_last;
      end
      lfp_pkg::StUpdate: begin
        cmd_o.tick_update = out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  // output word valid
  always_comb begin
    out_valid_d = out_valid_q && !led_mask_ready_i;
    if (state_q == lfp_pkg::StUpdate && out_free) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lfp_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign tick_ready_o     = (state_q == lfp_pkg::StIdle);
  assign led_mask_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ----- hdl/lfp_dp.sv -----
// datapath: config registers, random generator, serial remainder unit, led state
`timescale 1ns / 1ps
`default_nettype none
module lfp_dp #(
  parameter int unsigned LED_COUNT = lfp_pkg::LedCountDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [lfp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [lfp_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire lfp_pkg::lfp_cmd_t             cmd_i,
  output lfp_pkg::lfp_sts_t                  sts_o,
  output logic [lfp_pkg::MaskW-1:0]          led_mask_o
);

  localparam int unsigned LedIdxW  = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int unsigned MaskLeds = (LED_COUNT < lfp_pkg::MaskW) ? LED_COUNT : lfp_pkg::MaskW;
  localparam int unsigned SeedW    = lfp_pkg::SeedW;
  localparam int unsigned DelayW   = lfp_pkg::DelayW;
  localparam int unsigned BrightW  = lfp_pkg::BrightW;
  localparam int unsigned LevelW   = lfp_pkg::LevelW;
  localparam logic [LedIdxW-1:0] LedLast  = LedIdxW'(LED_COUNT - 1);
  localparam logic [LevelW-1:0]  LevelMax = LevelW'(lfp_pkg::LevelCount - 1);

  // configuration and generator state
  logic [BrightW-1:0] bright_span_q, bright_base_q;
  logic [DelayW-1:0]  delay_span_q, delay_base_q;
  logic [SeedW-1:0]   seed_q, lcg_next;

  // serial remainder unit
  logic [SeedW-1:0]                  dvd_q;
  logic [DelayW-1:0]                 rem_q, rem_d, rem_use;
  logic [lfp_pkg::BitCntW-1:0]       cnt_q;
  logic [DelayW-1:0]                 span_cur;
  logic [DelayW:0]                   trial;

  // led state
  logic [31:0]        pat_q  [LED_COUNT];
  logic [DelayW-1:0]  hold_q [LED_COUNT];
  logic [LedIdxW-1:0] led_q;
  logic [lfp_pkg::MaskW-1:0] mask_q, mask_d;

  // reload values
  logic [LevelW:0]     bright_sum;
  logic [LevelW-1:0]   level;
  logic [DelayW:0]     delay_sum;
  logic [DelayW-1:0]   hold_new;

  assign lcg_next = seed_q * lfp_pkg::LcgMul + lfp_pkg::LcgInc;

  // one restoring remainder step per cycle, dividend msb first
  always_comb begin
    span_cur = cmd_i.sel_delay ? delay_span_q : {{(DelayW-BrightW){1'b0}}, bright_span_q};
    trial    = {rem_q, dvd_q[SeedW-1]};
    if (trial >= {1'b0, span_cur}) rem_d = DelayW'(trial - {1'b0, span_cur});
    else                           rem_d = trial[DelayW-1:0];
    rem_use  = (span_cur == '0) ? '0 : rem_q;
  end

  // brightness level and hold delay with saturation
  always_comb begin
    bright_sum = {1'b0, rem_use[LevelW-1:0]} + (LevelW+1)'(1) + {1'b0, bright_base_q};
    level      = (bright_sum > {1'b0, LevelMax}) ? LevelMax : bright_sum[LevelW-1:0];
    delay_sum  = {1'b0, rem_use} + (DelayW+1)'(1) + {1'b0, delay_base_q};
    hold_new   = delay_sum[DelayW] ? '1 : delay_sum[DelayW-1:0];
  end

  // led output bits of the low lines
  always_comb begin
    mask_d = '0;
    for (int n = 0; n < MaskLeds; n++) begin
      mask_d[n] = pat_q[n][0];
    end
  end

  // configuration registers and random seed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q        <= lfp_pkg::SeedRst;
      bright_span_q <= lfp_pkg::BrightSpanRst;
      bright_base_q <= lfp_pkg::BrightBaseRst;
      delay_span_q  <= lfp_pkg::DelaySpanRst;
      delay_base_q  <= lfp_pkg::DelayBaseRst;
    end else begin
      if (cmd_i.lcg_step) seed_q <= lcg_next;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          lfp_pkg::CfgSeedStart:  seed_q        <= cfg_data_i[SeedW-1:0];
          lfp_pkg::CfgBrightSpan: bright_span_q <= cfg_data_i[BrightW-1:0];
          lfp_pkg::CfgBrightBase: bright_base_q <= cfg_data_i[BrightW-1:0];
          lfp_pkg::CfgDelaySpan:  delay_span_q  <= cfg_data_i[DelayW-1:0];
          lfp_pkg::CfgDelayBase:  delay_base_q  <= cfg_data_i[DelayW-1:0];
          default: ;
        endcase
      end
    end
  end

  // remainder unit bit counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // remainder unit data
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dvd_q <= lcg_next;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[SeedW-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  // led pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_q <= '0;
    end else if (cmd_i.led_clr) begin
      led_q <= '0;
    end else if (cmd_i.led_next) begin
      led_q <= led_q + 1'b1;
    end
  end

  // patterns and hold counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < LED_COUNT; n++) begin
        pat_q[n]  <= '0;
        hold_q[n] <= '0;
      end
    end else if (cmd_i.tick_update) begin
      for (int n = 0; n < LED_COUNT; n++) begin
        pat_q[n] <= {pat_q[n][0], pat_q[n][31:1]};
        if (hold_q[n] != '0) hold_q[n] <= hold_q[n] - 1'b1;
      end
    end else begin
      if (cmd_i.load_pattern) pat_q[led_q]  <= lfp_pkg::dither_word(level);
      if (cmd_i.load_hold)    hold_q[led_q] <= hold_new;
    end
  end

  // output word
  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_update) mask_q <= mask_d;
  end

  assign sts_o.hold_zero = (hold_q[led_q] == '0);
  assign sts_o.led_last  = (led_q == LedLast);
  assign sts_o.div_last  = (cnt_q == '1);
  assign led_mask_o      = mask_q;

endmodule
`default_nettype wire

// ----- hdl/led_flicker_pattern_pwm.sv -----
// top level of the led flicker pattern generator
// Each accepted tick word with tick set runs the LEDs through their dither patterns and
// returns one led_mask word; a word with tick clear is taken and gives no result. Every
// LED whose hold counter has run out lengthens the tick: each such LED needs two generator
// steps and each remainder is found one bit a cycle by a shared 32-step serial unit. A new
// tick is taken only once the previous one has been worked through, but the finished mask
// waits in its own output register, so the block takes the next tick while the mask is
// still unread; that tick's final update then waits until the earlier mask has been read.
// Registers must be written through the plain write port only while the block is idle;
// the block itself does not enforce this. Writing the seed also reloads the generator.
`timescale 1ns / 1ps
`default_nettype none
module led_flicker_pattern_pwm #(
  parameter int unsigned LED_COUNT = lfp_pkg::LedCountDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [lfp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [lfp_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          tick_valid_i,
  output logic                               tick_ready_o,
  input  wire logic                          tick_i,
  output logic                               led_mask_valid_o,
  input  wire logic                          led_mask_ready_i,
  output logic [lfp_pkg::MaskW-1:0]          led_mask_o
);

  lfp_pkg::lfp_cmd_t cmd;
  lfp_pkg::lfp_sts_t sts;

  // sequencing
  lfp_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tick_valid_i     (tick_valid_i),
    .tick_ready_o     (tick_ready_o),
    .tick_i           (tick_i),
    .led_mask_valid_o (led_mask_valid_o),
    .led_mask_ready_i (led_mask_ready_i),
    .cmd_o            (cmd),
    .sts_i            (sts)
  );

  // arithmetic and led state
  lfp_dp #(
    .LED_COUNT (LED_COUNT)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .led_mask_o (led_mask_o)
  );

endmodule
`default_nettype wire
